### rtl/fsca_pkg.sv
// ----------------------------------------------------------------------------
// fsca_pkg
// Shared constants and types for the parabolic sine/cosine approximation.
// ----------------------------------------------------------------------------
package fsca_pkg;

	localparam int ANG_MAG_W = 34;

	localparam logic [34:0] PI_Q32      = 35'h3243F6A89;
	localparam logic [34:0] TWO_PI_Q32  = 35'h6487ED511;
	localparam logic [34:0] HALF_PI_Q32 = 35'h1921FB544;

	localparam logic [30:0] ONE_Q30  = 31'h40000000;
	localparam logic [30:0] LIN_Q30  = 31'd1367130546;
	localparam logic [28:0] SQR_Q30  = 29'd435171171;
	localparam logic [27:0] CORR_Q30 = 28'd241591910;

	// wrapped angle in sign and magnitude, magnitude at most pi in Q.32
	typedef struct packed {
		logic                 neg;
		logic [ANG_MAG_W-1:0] mag;
	} ang_t;

endpackage

### rtl/fsca_wrap.sv
// ----------------------------------------------------------------------------
// fsca_wrap
// Scales the angle to Q.32, adds pi/2 for cosine and wraps it into [-pi, pi]
// with a reciprocal estimate of the whole turns and one correcting subtract.
// ----------------------------------------------------------------------------
module fsca_wrap #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic               in_func,
	input  logic signed [31:0] in_angle,
	output logic               out_vld,
	output fsca_pkg::ang_t     out_ang
);

	localparam int MAG_W = 65 - ANGLE_FRAC_BITS;
	localparam int X_W   = MAG_W + 1;
	localparam int SHL   = 32 - ANGLE_FRAC_BITS;
	localparam int USH   = MAG_W - 32;
	localparam int KW    = MAG_W - 34;
	localparam int RSH   = 66 - USH;
	localparam int KD_W  = KW + 35;
	localparam logic [31:0] RECIP = 32'((67'd1 << 66) / 67'(fsca_pkg::TWO_PI_Q32));

	logic signed [X_W-1:0] x_d;
	logic signed [X_W-1:0] x_s1;
	logic                  vld_s1;

	logic [X_W-1:0]   xabs_d;
	logic [MAG_W-1:0] mag_s2;
	logic             sgn_s2;
	logic             vld_s2;

	logic [MAG_W-1:0] t_s3;
	logic             small_s3;
	logic             sgn_s3;
	logic             vld_s3;

	logic [63:0]   kest_p;
	logic [KW-1:0] k_s4;
	logic [35:0]   t_s4;
	logic          small_s4;
	logic          sgn_s4;
	logic          vld_s4;

	logic [KD_W-1:0] kd_p;
	logic [35:0]     rem_s5;
	logic            small_s5;
	logic            sgn_s5;
	logic            vld_s5;

	logic [34:0] rem_s6;
	logic        small_s6;
	logic        sgn_s6;
	logic        vld_s6;

	logic signed [35:0] w_d;
	logic signed [35:0] w_s7;
	logic               sgn_s7;
	logic               vld_s7;

	logic [35:0]    wabs_d;
	fsca_pkg::ang_t ang_q;
	logic           vld_q;

	assign x_d = (X_W'(in_angle) <<< SHL)
		+ $signed({{(X_W-35){1'b0}}, (in_func ? fsca_pkg::HALF_PI_Q32 : 35'd0)});

	assign xabs_d = x_s1[X_W-1] ? -x_s1 : x_s1;

	// turn count estimate, never above the true count and at most one below
	assign kest_p = {32'd0, t_s3[MAG_W-1:USH]} * {32'd0, RECIP};
	assign kd_p   = KD_W'(k_s4) * KD_W'(fsca_pkg::TWO_PI_Q32);

	assign w_d = small_s6 ? $signed({1'b0, rem_s6})
		: $signed({1'b0, rem_s6}) - $signed({1'b0, fsca_pkg::PI_Q32}) + 36'sd1;

	assign wabs_d = w_s7[35] ? -w_s7 : w_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_q  <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_d;
			sgn_s2 <= x_s1[X_W-1];
			mag_s2 <= xabs_d[MAG_W-1:0];
			sgn_s3 <= sgn_s2;
			if (mag_s2 <= MAG_W'(fsca_pkg::PI_Q32)) begin
				small_s3 <= 1'b1;
				t_s3     <= mag_s2;
			end else begin
				small_s3 <= 1'b0;
				t_s3     <= mag_s2 - MAG_W'(fsca_pkg::PI_Q32) - MAG_W'(1);
			end
			k_s4     <= kest_p[63:RSH];
			t_s4     <= t_s3[35:0];
			small_s4 <= small_s3;
			sgn_s4   <= sgn_s3;
			rem_s5   <= t_s4 - kd_p[35:0];
			small_s5 <= small_s4;
			sgn_s5   <= sgn_s4;
			if (rem_s5 >= 36'(fsca_pkg::TWO_PI_Q32)) begin
				rem_s6 <= 35'(rem_s5 - 36'(fsca_pkg::TWO_PI_Q32));
			end else begin
				rem_s6 <= rem_s5[34:0];
			end
			small_s6  <= small_s5;
			sgn_s6    <= sgn_s5;
			w_s7      <= w_d;
			sgn_s7    <= sgn_s6;
			ang_q.neg <= sgn_s7 ? (w_s7 > 36'sd0) : (w_s7 < 36'sd0);
			ang_q.mag <= wabs_d[fsca_pkg::ANG_MAG_W-1:0];
		end
	end

	assign out_vld = vld_q;
	assign out_ang = ang_q;

endmodule

### rtl/fsca_shape.sv
// ----------------------------------------------------------------------------
// fsca_shape
// Parabola, precision correction, output scaling and saturation on the
// wrapped angle magnitude, one multiplier level per pipeline stage.
// ----------------------------------------------------------------------------
module fsca_shape #(
	parameter int OUT_FRAC_BITS = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  fsca_pkg::ang_t in_ang,
	output logic           out_vld,
	output logic [15:0]    out_value
);

	localparam int SH = 30 - OUT_FRAC_BITS;
	localparam logic [31:0] NEG_CAP = (OUT_FRAC_BITS >= 15) ? 32'd32768
		: (32'd1 << OUT_FRAC_BITS);

	logic [7:0] vld_q;
	logic       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;

	logic [31:0] a30_d;
	logic [62:0] lin_p;
	logic [63:0] sq_p;
	logic [32:0] lin_s1, lin_s2;
	logic [33:0] sq_s1;

	logic [62:0] quad_p;
	logic [32:0] quad_s2;

	logic [32:0] diff_d;
	logic [30:0] m_d;
	logic [30:0] m_s3, m_s4, m_s5;

	logic [30:0] om_d;
	logic [61:0] q_p;
	logic [30:0] q_s4;

	logic [58:0] c_p;
	logic [28:0] corr_s5;

	logic [30:0] r_s6;
	logic [31:0] scaled_d;
	logic [31:0] scaled_s7;

	logic [31:0] lim_d;
	logic [31:0] sat_d;
	logic [16:0] mag17_d;
	logic [15:0] value_d;
	logic [15:0] value_s8;

	assign a30_d  = in_ang.mag[33:2];
	assign lin_p  = {32'd0, fsca_pkg::LIN_Q30} * {31'd0, a30_d};
	assign sq_p   = {32'd0, a30_d} * {32'd0, a30_d};
	assign quad_p = {34'd0, fsca_pkg::SQR_Q30} * {29'd0, sq_s1};

	assign diff_d = lin_s2 - quad_s2;
	always_comb begin
		if (quad_s2 >= lin_s2) begin
			m_d = 31'd0;
		end else if (diff_d > {2'd0, fsca_pkg::ONE_Q30}) begin
			m_d = fsca_pkg::ONE_Q30;
		end else begin
			m_d = diff_d[30:0];
		end
	end

	assign om_d = fsca_pkg::ONE_Q30 - m_s3;
	assign q_p  = {31'd0, m_s3} * {31'd0, om_d};
	assign c_p  = {31'd0, fsca_pkg::CORR_Q30} * {28'd0, q_s4};

	if (SH > 0) begin : g_round
		assign scaled_d = 32'((33'(r_s6) + (33'd1 << (SH - 1))) >> SH);
	end else if (SH < 0) begin : g_widen
		assign scaled_d = 32'(r_s6) << (-SH);
	end else begin : g_keep
		assign scaled_d = 32'(r_s6);
	end

	assign lim_d   = neg_s7 ? NEG_CAP : NEG_CAP - 32'd1;
	assign sat_d   = (scaled_s7 > lim_d) ? lim_d : scaled_s7;
	assign mag17_d = sat_d[16:0];
	assign value_d = neg_s7 ? 16'(17'd0 - mag17_d) : mag17_d[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1    <= in_ang.neg;
			lin_s1    <= lin_p[62:30];
			sq_s1     <= sq_p[63:30];
			neg_s2    <= neg_s1;
			lin_s2    <= lin_s1;
			quad_s2   <= quad_p[62:30];
			neg_s3    <= neg_s2;
			m_s3      <= m_d;
			neg_s4    <= neg_s3;
			m_s4      <= m_s3;
			q_s4      <= q_p[60:30];
			neg_s5    <= neg_s4;
			m_s5      <= m_s4;
			corr_s5   <= c_p[58:30];
			neg_s6    <= neg_s5;
			r_s6      <= m_s5 - {2'd0, corr_s5};
			neg_s7    <= neg_s6;
			scaled_s7 <= scaled_d;
			value_s8  <= value_d;
		end
	end

	assign out_vld   = vld_q[7];
	assign out_value = value_s8;

endmodule

### rtl/fast_sine_cosine_approx_top.sv
// ----------------------------------------------------------------------------
// fast_sine_cosine_approx_top
// Streaming parabolic sine/cosine approximation with precision correction.
// ----------------------------------------------------------------------------
// Takes one angle word per clock unless the output stalls, and returns one
// Q1.15 word per angle, in order. Eight stages wrap the angle, with the
// whole turns counted by a reciprocal multiply and fixed by one compare and
// subtract, and eight more run the parabola, the correction and the output
// saturation. The whole pipeline shares one enable, so a stall at the output
// freezes every stage and the input stays ready whenever the output word is
// free or taken.
module fast_sine_cosine_approx_top #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS   = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // angle[31:0]
	input  logic [0:0]  s_axis_tuser,  // func[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // value[15:0]
);

	logic           en;
	logic           ang_vld;
	fsca_pkg::ang_t ang;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	fsca_wrap #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_wrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_axis_tvalid),
		.in_func  (s_axis_tuser[0]),
		.in_angle ($signed(s_axis_tdata)),
		.out_vld  (ang_vld),
		.out_ang  (ang)
	);

	fsca_shape #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (ang_vld),
		.in_ang    (ang),
		.out_vld   (m_axis_tvalid),
		.out_value (m_axis_tdata)
	);

	// wrapped magnitude never exceeds pi
	assert property (@(posedge clk) disable iff (!arst_n)
		ang_vld |-> ({1'b0, ang.mag} <= fsca_pkg::PI_Q32))
		else $error("wrapped angle outside [-pi, pi]");

	// a zero angle carries no sign
	assert property (@(posedge clk) disable iff (!arst_n)
		(ang_vld && ang.neg) |-> (ang.mag != '0))
		else $error("negative zero after wrap");

	// a held output word freezes the inner pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(ang_vld) && $stable(ang)))
		else $error("pipeline moved during output stall");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fast_sine_cosine_approx_top. Angle words go in as
// a short directed table and then as random bursts, with random output
// stalls. Results are checked in order of acceptance against typed table
// values or a bit-exact predictor of wrap, parabola, correction, saturation.
// ----------------------------------------------------------------------------
module tb;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS   = 15;
	localparam int N_RANDOM        = 1300;
	localparam int DRAIN_CYCLES    = 60;
	localparam int RUN_LIMIT       = 400000;
	localparam int N_DIRECTED      = 23;

	// angle constants in Q.32 (the last in Q.30), polynomial constants in Q.30
	localparam longint ANG_PI          = 64'sh3243F6A89;
	localparam longint ANG_TWO_PI      = 64'sh6487ED511;
	localparam longint ANG_HALF_PI     = 64'sh1921FB544;
	localparam longint ANG_HALF_PI_Q30 = 64'sd1686629713;

	localparam longint unsigned POLY_ONE  = 64'h40000000;
	localparam longint unsigned POLY_LIN  = 64'd1367130546;
	localparam longint unsigned POLY_SQR  = 64'd435171171;
	localparam longint unsigned POLY_CORR = 64'd241591910;

	typedef enum logic {
		FN_SINE   = 1'b0,
		FN_COSINE = 1'b1
	} func_e;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_e;

	typedef struct packed {
		func_e       func;
		logic [31:0] angle;
		logic        typed;
		logic [15:0] value;
	} stim_row_t;

	typedef struct packed {
		func_e       func;
		logic [31:0] angle;
		logic [15:0] value;
	} pending_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // angle[31:0]
	logic [0:0]  s_axis_tuser;  // func[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // value[15:0]

	// expected value travels beside the word for typed table rows
	logic        row_typed;
	logic [15:0] row_value;

	pending_t    pending_q[$];
	pending_t    new_pend;
	pending_t    old_pend;
	int          n_fail    = 0;
	int          cycle_cnt = 0;
	int          burst_left = 0;
	rx_mode_e    rx_mode   = RX_FREE;
	int          rx_left   = 0;
	logic [7:0]  rx_pat    = 8'h00;

	stim_row_t dir_rows [N_DIRECTED] = '{
		'{FN_SINE,   32'h00000000, 1'b1, 16'h0000},
		'{FN_COSINE, 32'h00000000, 1'b1, 16'h7FFF},
		'{FN_SINE,   32'h7FFFFFFF, 1'b0, 16'h0000},
		'{FN_SINE,   32'h80000000, 1'b0, 16'h0000},
		'{FN_COSINE, 32'h7FFFFFFF, 1'b0, 16'h0000},
		'{FN_COSINE, 32'h80000000, 1'b0, 16'h0000},
		'{FN_SINE,   32'h0001921F, 1'b0, 16'h0000},
		'{FN_SINE,   32'hFFFE6DE1, 1'b0, 16'h0000},
		'{FN_SINE,   32'h0003243F, 1'b0, 16'h0000},
		'{FN_SINE,   32'h00032440, 1'b0, 16'h0000},
		'{FN_SINE,   32'hFFFCDBC1, 1'b0, 16'h0000},
		'{FN_SINE,   32'hFFFCDBC0, 1'b0, 16'h0000},
		'{FN_SINE,   32'h0004B65F, 1'b0, 16'h0000},
		'{FN_SINE,   32'h0006487F, 1'b0, 16'h0000},
		'{FN_SINE,   32'hFFFFFFFF, 1'b0, 16'h0000},
		'{FN_SINE,   32'h00000001, 1'b0, 16'h0000},
		'{FN_COSINE, 32'hFFFFFFFF, 1'b0, 16'h0000},
		'{FN_COSINE, 32'h0001921F, 1'b0, 16'h0000},
		'{FN_COSINE, 32'hFFFE6DE1, 1'b0, 16'h0000},
		'{FN_COSINE, 32'h0003243F, 1'b0, 16'h0000},
		'{FN_SINE,   32'h00010000, 1'b0, 16'h0000},
		'{FN_SINE,   32'h0000C90F, 1'b0, 16'h0000},
		'{FN_COSINE, 32'h00DEAD00, 1'b0, 16'h0000}
	};

	fast_sine_cosine_approx_top #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.OUT_FRAC_BITS  (OUT_FRAC_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	function automatic logic [15:0] sincos_q15(input func_e func, input logic [31:0] angle);
		longint          x;
		longint          v;
		longint unsigned d, k, a, lin, sq, quad, m, q, r;
		logic            neg;
		int              sh;
		x = longint'($signed(angle)) * (longint'(1) << (32 - ANGLE_FRAC_BITS));
		if (func == FN_COSINE) begin
			x = x + ANG_HALF_PI;
		end
		// remove whole turns so the angle lands in [-pi, pi]
		if (x > ANG_PI) begin
			d = longint'(x - ANG_PI);
			k = (d + ANG_TWO_PI - 1) / ANG_TWO_PI;
			x = x - longint'(k * ANG_TWO_PI);
		end else if (x < -ANG_PI) begin
			d = longint'(-x - ANG_PI);
			k = (d + ANG_TWO_PI - 1) / ANG_TWO_PI;
			x = x + longint'(k * ANG_TWO_PI);
		end
		neg = (x < 0);
		a = neg ? -x : x;
		a = a >> 2;
		lin = (POLY_LIN * a) >> 30;
		sq = (a * a) >> 30;
		quad = (POLY_SQR * sq) >> 30;
		m = (quad >= lin) ? 64'd0 : lin - quad;
		if (m > POLY_ONE) begin
			m = POLY_ONE;
		end
		q = (m * (POLY_ONE - m)) >> 30;
		r = m - ((POLY_CORR * q) >> 30);
		sh = 30 - OUT_FRAC_BITS;
		if (sh > 0) begin
			r = (r + (64'd1 << (sh - 1))) >> sh;
		end else if (sh < 0) begin
			r = r << (-sh);
		end
		if (neg) begin
			if (r > (64'd1 << OUT_FRAC_BITS)) begin
				r = 64'd1 << OUT_FRAC_BITS;
			end
			v = -longint'(r);
		end else begin
			if (r > (64'd1 << OUT_FRAC_BITS) - 1) begin
				r = (64'd1 << OUT_FRAC_BITS) - 1;
			end
			v = longint'(r);
		end
		if (v > 32767) begin
			v = 32767;
		end
		if (v < -32768) begin
			v = -32768;
		end
		return v[15:0];
	endfunction

	function automatic logic [31:0] rand_angle();
		logic [31:0] a;
		longint      t;
		int          k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				a = $urandom;
			end
			4, 5, 6: begin
				// within two turns either way
				a = $urandom_range(0, 1647100) - 32'd823550;
			end
			7, 8: begin
				// close to a multiple of pi/2
				k = int'($urandom_range(0, 16)) - 8;
				t = (longint'(k) * ANG_HALF_PI_Q30) >>> (30 - ANGLE_FRAC_BITS);
				a = t[31:0] + $urandom_range(0, 16) - 32'd8;
			end
			default: begin
				a = $urandom_range(0, 255) + ($urandom_range(0, 1) ? 32'h7FFFFF00 : 32'h80000000);
			end
		endcase
		return a;
	endfunction

	task automatic idle(input int n);
		repeat (n) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			s_axis_tuser  <= 1'($urandom_range(0, 1));
		end
	endtask

	task automatic idle_until_empty();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// bursts of random length, random gaps between them
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				idle($urandom_range(1, 8));
			end
		end
		burst_left = burst_left - 1;
	endtask

	task automatic send_word(input func_e func, input logic [31:0] angle,
				 input logic typed, input logic [15:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= angle;
		s_axis_tuser  <= func;
		row_typed     <= typed;
		row_value     <= value;
		do begin
			@(posedge clk);
		end while (s_axis_tready !== 1'b1);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 80);
			rx_pat  = 8'($urandom);
		end
		rx_left = rx_left - 1;
		rx_pat  = {rx_pat[6:0], rx_pat[7]};
		case (rx_mode)
			RX_FREE:    m_axis_tready <= 1'b1;
			RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
			RX_PATTERN: m_axis_tready <= rx_pat[0];
			default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				new_pend.func  = func_e'(s_axis_tuser[0]);
				new_pend.angle = s_axis_tdata;
				new_pend.value = row_typed ? row_value : sincos_q15(func_e'(s_axis_tuser[0]), s_axis_tdata);
				pending_q.push_back(new_pend);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_q.size() == 0) begin
					n_fail = n_fail + 1;
					if (n_fail <= 10) begin
						$display("unexpected result word %h", m_axis_tdata);
					end
				end else begin
					old_pend = pending_q.pop_front();
					if (m_axis_tdata !== old_pend.value) begin
						n_fail = n_fail + 1;
						if (n_fail <= 10) begin
							$display("mismatch: func %0d angle %h expected %h got %h",
								 old_pend.func, old_pend.angle, old_pend.value, m_axis_tdata);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 32'h0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		row_typed     = 1'b0;
		row_value     = 16'h0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < N_DIRECTED; i++) begin
			pace();
			send_word(dir_rows[i].func, dir_rows[i].angle, dir_rows[i].typed, dir_rows[i].value);
		end
		idle_until_empty();

		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				idle_until_empty();
			end
			pace();
			send_word(func_e'($urandom_range(0, 1)), rand_angle(), 1'b0, 16'h0);
		end
		idle_until_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_fail == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### fast_sine_cosine_approx_top.f
rtl/fsca_pkg.sv
rtl/fsca_wrap.sv
rtl/fsca_shape.sv
rtl/fast_sine_cosine_approx_top.sv
tb/tb.sv
